>>> hdl/pauli_product_phase_engine_defines.svh
// Assertion helpers used by the checker of the Pauli product engine.
`ifndef PAULI_PRODUCT_PHASE_ENGINE_DEFINES_SVH
`define PAULI_PRODUCT_PHASE_ENGINE_DEFINES_SVH

// Check a property on every rising clk edge while out of reset.
`define PPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define PPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ppe_pkg.sv
`timescale 1ns / 1ps

package ppe_pkg;

  // Qubits carried by one word on the ports.
  localparam int unsigned LANES = 64;

  // Qubits actually in use per word; lanes above it are dropped.
  localparam int unsigned WORD_WIDTH = 64;

  localparam logic [LANES-1:0] LANE_MASK =
    (WORD_WIDTH >= LANES) ? {LANES{1'b1}} : (({{(LANES-1){1'b0}}, 1'b1} << WORD_WIDTH) - 1'b1);

  typedef struct packed {
    logic [LANES-1:0] left_x;
    logic [LANES-1:0] left_z;
    logic [LANES-1:0] right_x;
    logic [LANES-1:0] right_z;
    logic             left_sign;
    logic             right_sign;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [LANES-1:0] product_x;
    logic [LANES-1:0] product_z;
    logic             last_out;
    logic [1:0]       phase_exponent;
    logic             product_sign;
    logic             imaginary;
    logic             strings_commute;
  } out_item_t;

endpackage

>>> hdl/pauli_product_phase_engine.sv
`timescale 1ns / 1ps

// Pauli string product engine. Each transfer on the in_ channel carries one
// word of 64 qubits of both operands; each transfer on the out_ channel returns
// the matching product word, in order, one result per input word. A word is
// taken every cycle while out_ does not stall; its result passes the input
// register, then the result register, before it is offered on out_; either
// side may stall at any time.
// Without stalls on out_, the sustained rate of one word per cycle is set by the
// per-lane mod-4 phase counters, which are read and updated once per word. On
// the word flagged last the counters are reduced by a mod-4 popcount tree, the
// right sign is folded in, the scalar fields (phase exponent of i, sign,
// imaginary, commute) are reported with that word and the counters clear, so
// the next word starts a new product. Scalar fields read zero on other words.
module pauli_product_phase_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppe_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ppe_pkg::out_item_t  out_data
);

  logic                      in_valid_r;
  ppe_pkg::in_item_t         in_data_r;
  logic                      out_valid_r;
  ppe_pkg::out_item_t        out_data_r;
  ppe_pkg::out_item_t        out_data_nxt;
  logic [ppe_pkg::LANES-1:0] count_lo_r;
  logic [ppe_pkg::LANES-1:0] count_hi_r;
  logic [ppe_pkg::LANES-1:0] count_lo_nxt;
  logic [ppe_pkg::LANES-1:0] count_hi_nxt;
  logic                      advance;

  logic [ppe_pkg::LANES-1:0] lx, lz, rx, rz;
  logic [ppe_pkg::LANES-1:0] px, pz, lx_rz, anti;
  logic [ppe_pkg::LANES-1:0] lo_upd, hi_upd;
  logic [1:0]                phase;

  // Popcount mod 4 through a balanced tree of 2-bit adders.
  function automatic logic [1:0] ones_mod4(input logic [ppe_pkg::LANES-1:0] v);
    logic [1:0] acc [ppe_pkg::LANES];
    for (int i = 0; i < ppe_pkg::LANES; i++) begin
      acc[i] = {1'b0, v[i]};
    end
    for (int step = 1; step < ppe_pkg::LANES; step = step * 2) begin
      for (int i = 0; i + step < ppe_pkg::LANES; i = i + 2 * step) begin
        acc[i] = acc[i] + acc[i + step];
      end
    end
    return acc[0];
  endfunction

  // Move the held word into the result register when it is empty or drains.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    lx     = in_data_r.left_x  & ppe_pkg::LANE_MASK;
    lz     = in_data_r.left_z  & ppe_pkg::LANE_MASK;
    rx     = in_data_r.right_x & ppe_pkg::LANE_MASK;
    rz     = in_data_r.right_z & ppe_pkg::LANE_MASK;
    px     = lx ^ rx;
    pz     = lz ^ rz;
    lx_rz  = lx & rz;
    anti   = (rx & lz) ^ lx_rz;
    hi_upd = count_hi_r ^ ((count_lo_r ^ px ^ pz ^ lx_rz) & anti);
    lo_upd = count_lo_r ^ anti;
    // High bits only count twice, so their parity is all that matters mod 4.
    phase  = ones_mod4(lo_upd) + {^hi_upd, 1'b0} + {in_data_r.right_sign, 1'b0};

    out_data_nxt.product_x       = px;
    out_data_nxt.product_z       = pz;
    out_data_nxt.last_out        = in_data_r.last;
    out_data_nxt.phase_exponent  = 2'b00;
    out_data_nxt.product_sign    = 1'b0;
    out_data_nxt.imaginary       = 1'b0;
    out_data_nxt.strings_commute = 1'b0;
    count_lo_nxt                 = lo_upd;
    count_hi_nxt                 = hi_upd;
    if (in_data_r.last) begin
      out_data_nxt.phase_exponent  = phase;
      out_data_nxt.product_sign    = in_data_r.left_sign ^ phase[1];
      out_data_nxt.imaginary       = phase[0];
      out_data_nxt.strings_commute = !phase[0];
      count_lo_nxt                 = '0;
      count_hi_nxt                 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_lo_r  <= '0;
      count_hi_r  <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        count_lo_r  <= count_lo_nxt;
        count_hi_r  <= count_hi_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> hdl/ppe_chk.sv
`timescale 1ns / 1ps

`include "pauli_product_phase_engine_defines.svh"

module ppe_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ppe_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ppe_pkg::out_item_t out_data
);

  `PPE_ASSERT_ALWAYS(a_idle_after_reset, $past(!rst_n) |-> !out_valid, "result valid right after reset")
  `PPE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `PPE_ASSERT(a_scalar_zero, out_valid && !out_data.last_out |-> out_data.phase_exponent == 2'b00 && !out_data.product_sign && !out_data.imaginary && !out_data.strings_commute, "scalar fields set on a word not last")
  `PPE_ASSERT(a_scalar_consistent, out_valid && out_data.last_out |-> out_data.imaginary == out_data.phase_exponent[0] && out_data.strings_commute == !out_data.phase_exponent[0], "imaginary or commute flag disagrees with phase")
  `PPE_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty result stage")

endmodule

bind pauli_product_phase_engine ppe_chk u_ppe_chk (.*);

>>> bench/tb_pauli_product_phase_engine.sv
`timescale 1ns / 1ps

module tb_pauli_product_phase_engine;

  class phase_tracker;
    logic [ppe_pkg::LANES-1:0] lane_low;
    logic [ppe_pkg::LANES-1:0] lane_high;
    ppe_pkg::out_item_t        product_queue[$];
    int unsigned               fail_count;

    function new();
      lane_low    = '0;
      lane_high   = '0;
      fail_count  = 0;
    endfunction

    function int unsigned pending();
      return product_queue.size();
    endfunction

    // Work out the product word and, on last, the scalar of one accepted transfer.
    function void note_word(ppe_pkg::in_item_t w);
      logic [ppe_pkg::LANES-1:0] lx, lz, rx, rz, px, pz, lx_rz, anti;
      int unsigned               e;
      ppe_pkg::out_item_t        want;
      lx    = w.left_x & ppe_pkg::LANE_MASK;
      lz    = w.left_z & ppe_pkg::LANE_MASK;
      rx    = w.right_x & ppe_pkg::LANE_MASK;
      rz    = w.right_z & ppe_pkg::LANE_MASK;
      px    = lx ^ rx;
      pz    = lz ^ rz;
      lx_rz = lx & rz;
      anti  = (rx & lz) ^ lx_rz;
      // carry into bit 1 of each lane count before bit 0 moves
      lane_high = lane_high ^ ((lane_low ^ px ^ pz ^ lx_rz) & anti);
      lane_low  = lane_low ^ anti;
      want = '0;
      want.product_x = px;
      want.product_z = pz;
      want.last_out  = w.last;
      if (w.last) begin
        e = ($countones(lane_low) + 2 * $countones(lane_high) + 2 * w.right_sign) % 4;
        want.phase_exponent  = e[1:0];
        want.product_sign    = w.left_sign ^ e[1];
        want.imaginary       = e[0];
        want.strings_commute = ~e[0];
        lane_low  = '0;
        lane_high = '0;
      end
      product_queue = {product_queue, want};
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %h, got %h", field, want, got);
    endfunction

    function void check_word(ppe_pkg::out_item_t got);
      ppe_pkg::out_item_t want;
      if (product_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: result %h with nothing outstanding", got);
        return;
      end
      want = product_queue.pop_front();
      if (got.product_x !== want.product_x)
        report("product_x", want.product_x, got.product_x);
      if (got.product_z !== want.product_z)
        report("product_z", want.product_z, got.product_z);
      if (got.last_out !== want.last_out)
        report("last_out", 64'(want.last_out), 64'(got.last_out));
      if (got.phase_exponent !== want.phase_exponent)
        report("phase_exponent", 64'(want.phase_exponent), 64'(got.phase_exponent));
      if (got.product_sign !== want.product_sign)
        report("product_sign", 64'(want.product_sign), 64'(got.product_sign));
      if (got.imaginary !== want.imaginary)
        report("imaginary", 64'(want.imaginary), 64'(got.imaginary));
      if (got.strings_commute !== want.strings_commute)
        report("strings_commute", 64'(want.strings_commute), 64'(got.strings_commute));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  ppe_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  ppe_pkg::out_item_t out_data;

  phase_tracker tracker;
  int unsigned  send_idle_pct;
  int unsigned  stall_pct;
  int unsigned  words_sent;

  pauli_product_phase_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: decide ready at every falling edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_word(out_data);
  end

  function automatic ppe_pkg::in_item_t make_word(logic [63:0] lx, logic [63:0] lz,
                                                  logic [63:0] rx, logic [63:0] rz,
                                                  logic ls, logic rs, logic last);
    ppe_pkg::in_item_t w;
    w.left_x     = lx;
    w.left_z     = lz;
    w.right_x    = rx;
    w.right_z    = rz;
    w.left_sign  = ls;
    w.right_sign = rs;
    w.last       = last;
    return w;
  endfunction

  function automatic logic [63:0] rand_lanes();
    logic [63:0] v;
    int unsigned pick;
    pick = $urandom_range(9);
    v = {$urandom, $urandom};
    if (pick == 0)
      v = '0;
    else if (pick == 1)
      v = '1;
    else if (pick <= 3)
      v = v & {$urandom, $urandom} & {$urandom, $urandom};
    else if (pick == 4)
      v = v | {$urandom, $urandom};
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_word(ppe_pkg::in_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_word(make_word(rand_lanes(), rand_lanes(), rand_lanes(), rand_lanes(),
                          1'($urandom_range(1)), 1'($urandom_range(1)), k == len - 1));
  endtask

  task automatic send_directed();
    logic [63:0] ones;
    logic [63:0] lane;
    ones = '1;
    lane = 64'h1;
    // empty product, then full operands with both signs
    send_word(make_word('0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
    send_word(make_word(ones, ones, '0, '0, 1'b1, 1'b1, 1'b1));
    send_word(make_word('0, '0, ones, ones, 1'b0, 1'b1, 1'b1));
    // single-qubit products: XY, YX, XZ, ZX, YZ, ZY
    send_word(make_word(lane, '0, lane, lane, 1'b0, 1'b0, 1'b1));
    send_word(make_word(lane << 63, lane << 63, lane << 63, '0, 1'b1, 1'b0, 1'b1));
    send_word(make_word(lane << 7, '0, '0, lane << 7, 1'b0, 1'b0, 1'b1));
    send_word(make_word('0, lane << 31, lane << 31, '0, 1'b1, 1'b1, 1'b1));
    send_word(make_word(lane << 40, lane << 40, '0, lane << 40, 1'b0, 1'b0, 1'b1));
    send_word(make_word('0, lane << 2, lane << 2, lane << 2, 1'b0, 1'b1, 1'b1));
    // XY on every lane, then XZ on every lane
    send_word(make_word(ones, '0, ones, ones, 1'b0, 1'b1, 1'b1));
    send_word(make_word(ones, '0, '0, ones, 1'b1, 1'b0, 1'b1));
    // YY everywhere commutes
    send_word(make_word(ones, ones, ones, ones, 1'b1, 1'b1, 1'b1));
    // signs on words before last are dropped; lane 5 counts up to three
    send_word(make_word(lane << 5, '0, lane << 5, lane << 5, 1'b1, 1'b1, 1'b0));
    send_word(make_word(lane << 5, '0, lane << 5, lane << 5, 1'b1, 1'b0, 1'b0));
    send_word(make_word(lane << 5, '0, lane << 5, lane << 5, 1'b0, 1'b0, 1'b1));
    // four XY words on one lane wrap the count to zero
    for (int k = 0; k < 4; k++)
      send_word(make_word(lane, '0, lane, lane, 1'b1, 1'b1, k == 3));
    send_string(5);
    send_string(1);
  endtask

  initial begin
    tracker       = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    words_sent    = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 57;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 57;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct     = 30;
        end
      endcase
      if (ph == 0)
        send_directed();
      while (words_sent < 325 * (ph + 1)) begin
        if ($urandom_range(15) == 0)
          send_string($urandom_range(20, 7));
        else
          send_string($urandom_range(6, 1));
      end
    end
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
